>>> hdl/ehv_pkg.sv
package ehv_pkg;

  // Status codes reported on the result channel
  typedef logic [2:0] status_t;

  localparam status_t ST_OK          = 3'd0;
  localparam status_t ST_IN_HEADER   = 3'd1;
  localparam status_t ST_OFFSET_ALGN = 3'd2;
  localparam status_t ST_ADDR_ALGN   = 3'd3;
  localparam status_t ST_PAST_END    = 3'd4;
  localparam status_t ST_OUT_OF_RNG  = 3'd5;
  localparam status_t ST_BSS_RANGE   = 3'd6;
  localparam status_t ST_ENTRY       = 3'd7;

  // Configuration register indexes
  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t REG_IMAGE_LENGTH = 2'd0;
  localparam cfg_index_t REG_ENTRY_ADDR   = 2'd1;
  localparam cfg_index_t REG_BSS_ADDRESS  = 2'd2;
  localparam cfg_index_t REG_BSS_SIZE     = 2'd3;

  // Field widths fixed by the header format
  localparam int INDEX_W = 5;
  localparam int WORD_W  = 32;

  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [WORD_W-1:0]  word_t;

  // Allowed load windows, end bound inclusive
  localparam word_t WIN_A_LO = 32'h8000_3100;
  localparam word_t WIN_A_HI = 32'h8120_0000;
  localparam word_t WIN_B_LO = 32'h9300_0000;
  localparam word_t WIN_B_HI = 32'h933d_0000;

  // Low address bits that must be zero for 32-byte alignment
  localparam word_t LINE_MASK = 32'h0000_001f;

  // Result of checking one section entry
  typedef struct packed {
    status_t code;
    logic    entry_hit;
  } check_t;

  // True when [start, start+size) does not wrap and lies in a window
  function automatic logic span_allowed(word_t start, word_t size);
    logic [WORD_W:0] end_w;
    end_w = {1'b0, start} + {1'b0, size};
    return !end_w[WORD_W] &&
           ((start >= WIN_A_LO && end_w[WORD_W-1:0] <= WIN_A_HI) ||
            (start >= WIN_B_LO && end_w[WORD_W-1:0] <= WIN_B_HI));
  endfunction

endpackage

>>> hdl/ehv_sec_if.sv
// Section entry channel
interface ehv_sec_if;
  import ehv_pkg::*;

  logic   valid;
  logic   ready;
  index_t section_index;
  word_t  section_offset;
  word_t  section_address;
  word_t  section_len;

  modport source (
    output valid, section_index, section_offset, section_address, section_len,
    input  ready
  );

  modport sink (
    input  valid, section_index, section_offset, section_address, section_len,
    output ready
  );
endinterface

>>> hdl/ehv_res_if.sv
// Result channel
interface ehv_res_if #(
  parameter int SECTIONS = 18
);
  import ehv_pkg::*;

  logic                valid;
  logic                ready;
  status_t             status;
  logic                image_done;
  logic [SECTIONS-1:0] sections_present;

  modport source (
    output valid, status, image_done, sections_present,
    input  ready
  );

  modport sink (
    input  valid, status, image_done, sections_present,
    output ready
  );
endinterface

>>> hdl/ehv_check.sv
// Per-entry checks: error code in priority order and entry point hit
module ehv_check #(
  parameter int TEXT_SECTIONS = 7,
  parameter int HEADER_BYTES  = 256
) (
  input  ehv_pkg::index_t section_index,
  input  ehv_pkg::word_t  section_offset,
  input  ehv_pkg::word_t  section_address,
  input  ehv_pkg::word_t  section_len,
  input  ehv_pkg::word_t  image_length,
  input  ehv_pkg::word_t  entry_addr,
  output ehv_pkg::check_t result
);
  import ehv_pkg::*;

  localparam word_t HDR_LIMIT = WORD_W'(HEADER_BYTES);
  localparam logic [INDEX_W:0] TEXT_LIMIT = (INDEX_W+1)'(TEXT_SECTIONS);

  logic            nonempty;
  logic [WORD_W:0] round_sum;
  word_t           rounded;
  word_t           room;
  word_t           sec_end;
  logic            past_end;

  // Size rounded up to a 32-byte line; a carry out means it wrapped
  assign round_sum = {1'b0, section_len} + {1'b0, LINE_MASK};
  assign rounded   = round_sum[WORD_W-1:0] & ~LINE_MASK;
  assign room      = image_length - section_offset;
  assign nonempty  = section_len != '0;
  assign past_end  = round_sum[WORD_W] || (section_offset > image_length) ||
                     (rounded > room);

  // First failing check wins
  always_comb begin
    if (nonempty && section_offset < HDR_LIMIT) begin
      result.code = ST_IN_HEADER;
    end else if ((section_offset & LINE_MASK) != '0) begin
      result.code = ST_OFFSET_ALGN;
    end else if ((section_address & LINE_MASK) != '0) begin
      result.code = ST_ADDR_ALGN;
    end else if (past_end) begin
      result.code = ST_PAST_END;
    end else if (nonempty && !span_allowed(section_address, section_len)) begin
      result.code = ST_OUT_OF_RNG;
    end else begin
      result.code = ST_OK;
    end
  end

  // Entry point inside a text section; section end wraps modulo 2^32
  assign sec_end = section_address + section_len;
  assign result.entry_hit = ({1'b0, section_index} < TEXT_LIMIT) &&
                            (entry_addr >= section_address) &&
                            (entry_addr < sec_end);

endmodule

>>> hdl/executable_header_validator_unit.sv
// Executable header validator. Section table entries enter on the sec channel,
// one per transfer, and each produces exactly one result transfer. The unit
// takes one entry per clock unless the result channel stalls: an entry is
// held in an input register, checked by the logic between that register and
// the result register, and the sticky first-error code, entry-found flag and
// present mask are updated as it is loaded. Results carry the first error seen
// so far; the entry with index SECTIONS-1 also runs the bss and entry point
// checks, raises image_done with the present mask and clears the image state.
// Indexes of SECTIONS or more change nothing and report the kept error. The
// configuration registers are written through cfg_write_en, cfg_index and
// cfg_data by the user while no entry is in flight; the unit does not check.
module executable_header_validator_unit #(
  parameter int SECTIONS      = 18,
  parameter int TEXT_SECTIONS = 7,
  parameter int HEADER_BYTES  = 256
) (
  input  logic                clk,
  input  logic                rst,
  ehv_sec_if.sink             sec,
  ehv_res_if.source           res,
  input  logic                cfg_write_en,
  input  ehv_pkg::cfg_index_t cfg_index,
  input  ehv_pkg::word_t      cfg_data
);
  import ehv_pkg::*;

  localparam logic [INDEX_W:0] SEC_LIMIT = (INDEX_W+1)'(SECTIONS);
  localparam index_t           LAST_IDX  = INDEX_W'(SECTIONS - 1);

  // Configuration registers
  word_t image_length;
  word_t entry_addr;
  word_t bss_address;
  word_t bss_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_length <= '0;
      entry_addr   <= '0;
      bss_address  <= '0;
      bss_size     <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_IMAGE_LENGTH: image_length <= cfg_data;
        REG_ENTRY_ADDR:   entry_addr   <= cfg_data;
        REG_BSS_ADDRESS:  bss_address  <= cfg_data;
        REG_BSS_SIZE:     bss_size     <= cfg_data;
        default:          image_length <= image_length;
      endcase
    end
  end

  // Input register
  logic   s1_valid;
  index_t s1_index;
  word_t  s1_offset;
  word_t  s1_address;
  word_t  s1_size;
  logic   advance;

  assign advance   = !res.valid || res.ready;
  assign sec.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sec.ready) begin
      s1_valid <= sec.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sec.ready && sec.valid) begin
      s1_index   <= sec.section_index;
      s1_offset  <= sec.section_offset;
      s1_address <= sec.section_address;
      s1_size    <= sec.section_len;
    end
  end

  // Entry checks
  check_t chk;

  ehv_check #(
    .TEXT_SECTIONS (TEXT_SECTIONS),
    .HEADER_BYTES  (HEADER_BYTES)
  ) u_check (
    .section_index   (s1_index),
    .section_offset  (s1_offset),
    .section_address (s1_address),
    .section_len     (s1_size),
    .image_length    (image_length),
    .entry_addr      (entry_addr),
    .result          (chk)
  );

  // Image state
  status_t             first_error;
  logic                entry_found;
  logic [SECTIONS-1:0] present_mask;

  status_t             first_error_next;
  logic                entry_found_next;
  logic [SECTIONS-1:0] present_mask_next;

  status_t             status_next;
  logic                image_done_next;
  logic [SECTIONS-1:0] sections_present_next;

  logic                idx_ok;
  logic                is_last;
  logic                process;
  status_t             err_now;
  status_t             err_fin;
  logic                found_now;
  logic [SECTIONS-1:0] mask_now;

  assign idx_ok  = {1'b0, s1_index} < SEC_LIMIT;
  assign is_last = s1_index == LAST_IDX;
  assign process = s1_valid && advance;

  assign err_now   = (first_error == ST_OK) ? chk.code : first_error;
  assign found_now = entry_found || chk.entry_hit;
  assign mask_now  = present_mask |
                     ((s1_size != '0) ? (SECTIONS'(1) << s1_index) : '0);

  // Final verdict: bss span first, then entry point
  always_comb begin
    err_fin = err_now;
    if (err_fin == ST_OK && bss_size != '0 && !span_allowed(bss_address, bss_size)) begin
      err_fin = ST_BSS_RANGE;
    end
    if (err_fin == ST_OK && !found_now) begin
      err_fin = ST_ENTRY;
    end
  end

  // Result and state update for the entry in the input register
  always_comb begin
    first_error_next      = first_error;
    entry_found_next      = entry_found;
    present_mask_next     = present_mask;
    status_next           = first_error;
    image_done_next       = 1'b0;
    sections_present_next = '0;
    if (idx_ok && !is_last) begin
      first_error_next  = err_now;
      entry_found_next  = found_now;
      present_mask_next = mask_now;
      status_next       = err_now;
    end else if (idx_ok) begin
      first_error_next      = ST_OK;
      entry_found_next      = 1'b0;
      present_mask_next     = '0;
      status_next           = err_fin;
      image_done_next       = 1'b1;
      sections_present_next = mask_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_error  <= ST_OK;
      entry_found  <= 1'b0;
      present_mask <= '0;
    end else if (process) begin
      first_error  <= first_error_next;
      entry_found  <= entry_found_next;
      present_mask <= present_mask_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      res.status           <= status_next;
      res.image_done       <= image_done_next;
      res.sections_present <= sections_present_next;
    end
  end

  // Assertions
  logic last_done;
  assign last_done = process && idx_ok && is_last;

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    last_done |=> (first_error == ST_OK && !entry_found && present_mask == '0))
    else $error("image state not cleared after last section");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (first_error != ST_OK && !last_done) |=> $stable(first_error))
    else $error("kept error changed before end of image");

  a_mask_only_final: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.image_done) |-> (res.sections_present == '0))
    else $error("mask reported on a non-final result");

  a_ready_only_stall: assert property (@(posedge clk) disable iff (rst)
    !sec.ready |-> (s1_valid && res.valid && !res.ready))
    else $error("input stalled without a downstream stall");

endmodule
